/* design/ofs_pkg.sv */
// ---------------------------------------------------------------------------
// ofs_pkg: shared types for the order finding factor splitter
// Payload structs, controller commands, datapath status and operand selects.
// ---------------------------------------------------------------------------
package ofs_pkg;

  localparam int FIELD_W = 32;
  localparam int ORDER_W = 16;
  localparam int EXP_IDX_W = 4;

  typedef struct packed {
    logic [FIELD_W-1:0] modulus;
    logic [FIELD_W-1:0] base;
  } ofs_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] factor_a;
    logic [FIELD_W-1:0] factor_b;
    logic [ORDER_W-1:0] order;
    logic               status;
  } ofs_out_t;

  typedef enum logic [1:0] {
    MSEL_ACC_G   = 2'd0,
    MSEL_RES_RES = 2'd1,
    MSEL_RES_G   = 2'd2
  } ofs_msel_t;

  typedef enum logic [1:0] {
    DSEL_GMOD = 2'd0,
    DSEL_GCD  = 2'd1,
    DSEL_QUOT = 2'd2
  } ofs_dsel_t;

  typedef struct packed {
    logic      load;
    logic      init_g;
    logic      acc_take;
    logic      pow_init;
    logic      res_take;
    logic      k_dec;
    logic      gcd_init;
    logic      gcd_step;
    logic      mul_start;
    ofs_msel_t mul_sel;
    logic      div_start;
    ofs_dsel_t div_sel;
    logic      out_load;
    logic      out_fail;
  } ofs_cmd_t;

  typedef struct packed {
    logic n_ge2;
    logic limit_zero;
    logic mul_done;
    logic div_done;
    logic prod_one;
    logic r_last;
    logic rem_zero;
    logic exp_bit;
    logic k_zero;
    logic out_free;
  } ofs_status_t;

endpackage

/* design/ofs_ctrl.sv */
// ---------------------------------------------------------------------------
// ofs_ctrl: sequencer for the order finding factor splitter
// Steps through reduction, order search, power, gcd and final division.
// ---------------------------------------------------------------------------
module ofs_ctrl import ofs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ofs_status_t st,
  output ofs_cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_IDLE = 17'h00001,
    S_CHK  = 17'h00002,
    S_MODG = 17'h00004,
    S_SGO  = 17'h00008,
    S_SW   = 17'h00010,
    S_PSQ  = 17'h00020,
    S_PSQW = 17'h00040,
    S_PML  = 17'h00080,
    S_PMLW = 17'h00100,
    S_PNXT = 17'h00200,
    S_GDIV = 17'h00400,
    S_GW   = 17'h00800,
    S_QW   = 17'h01000,
    S_FIN  = 17'h02000,
    S_FAIL = 17'h04000,
    S_GINI = 17'h08000,
    S_QGO  = 17'h10000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = MSEL_ACC_G;
    cmd.div_sel = DSEL_GMOD;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (!st.n_ge2 || st.limit_zero) begin
          state_next = S_FAIL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = DSEL_GMOD;
          state_next = S_MODG;
        end
      end
      S_MODG: begin
        if (st.div_done) begin
          cmd.init_g = 1'b1;
          state_next = S_SGO;
        end
      end
      S_SGO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = MSEL_ACC_G;
        state_next = S_SW;
      end
      S_SW: begin
        if (st.mul_done) begin
          if (st.prod_one) begin
            cmd.pow_init = 1'b1;
            state_next = S_PSQ;
          end else if (st.r_last) begin
            state_next = S_FAIL;
          end else begin
            cmd.acc_take = 1'b1;
            state_next = S_SGO;
          end
        end
      end
      S_PSQ: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = MSEL_RES_RES;
        state_next = S_PSQW;
      end
      S_PSQW: begin
        if (st.mul_done) begin
          cmd.res_take = 1'b1;
          state_next = st.exp_bit ? S_PML : S_PNXT;
        end
      end
      S_PML: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel = MSEL_RES_G;
        state_next = S_PMLW;
      end
      S_PMLW: begin
        if (st.mul_done) begin
          cmd.res_take = 1'b1;
          state_next = S_PNXT;
        end
      end
      S_PNXT: begin
        if (st.k_zero) begin
          state_next = S_GINI;
        end else begin
          cmd.k_dec = 1'b1;
          state_next = S_PSQ;
        end
      end
      S_GINI: begin
        cmd.gcd_init = 1'b1;
        state_next = S_GDIV;
      end
      S_GDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DSEL_GCD;
        state_next = S_GW;
      end
      S_GW: begin
        if (st.div_done) begin
          if (st.rem_zero) begin
            state_next = S_QGO;
          end else begin
            cmd.gcd_step = 1'b1;
            state_next = S_GDIV;
          end
        end
      end
      S_QGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = DSEL_QUOT;
        state_next = S_QW;
      end
      S_QW: begin
        if (st.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FAIL: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_fail = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* design/ofs_dp.sv */
// ---------------------------------------------------------------------------
// ofs_dp: datapath for the order finding factor splitter
// Bit-serial modular multiplier, restoring divider, operand registers and
// the output register.
// ---------------------------------------------------------------------------
module ofs_dp import ofs_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ofs_in_t            in_data,
  input  logic [ORDER_W-1:0] limit,
  input  ofs_cmd_t           cmd,
  output ofs_status_t        st,
  output logic               out_valid,
  input  logic               out_stall,
  output ofs_out_t           out_data
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0]     n, graw, g, acc, res, dvd, dvs;
  logic [ORDER_W-1:0]   r, expo;
  logic [EXP_IDX_W-1:0] k;

  // multiplier
  logic [WIDTH-1:0] ma, mb, mp;
  logic [CW-1:0]    mcnt;
  logic             mphase, mbusy, mdone;
  logic [WIDTH-1:0] m_opa, m_opb, m_addend, m_sum;
  logic [WIDTH:0]   m_raw;

  // divider
  logic [WIDTH-1:0] dq, drm, dd;
  logic [CW-1:0]    dcnt;
  logic             dbusy, ddone;
  logic [WIDTH-1:0] d_num, d_den;
  logic [WIDTH:0]   d_t, d_diff;
  logic             d_ge;

  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_ACC_G:   begin m_opa = g;   m_opb = acc; end
      MSEL_RES_RES: begin m_opa = res; m_opb = res; end
      MSEL_RES_G:   begin m_opa = g;   m_opb = res; end
      default:      begin m_opa = g;   m_opb = acc; end
    endcase
  end

  // phase 0 doubles, phase 1 adds the multiplicand when the bit is set
  assign m_addend = mphase ? (mb[mcnt] ? ma : '0) : mp;
  assign m_raw = {1'b0, mp} + {1'b0, m_addend};
  assign m_sum = (m_raw >= {1'b0, n}) ? WIDTH'(m_raw - {1'b0, n}) : m_raw[WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mbusy <= 1'b0;
      mdone <= 1'b0;
    end else begin
      mdone <= 1'b0;
      if (cmd.mul_start) begin
        mbusy <= 1'b1;
      end else if (mbusy && mphase && (mcnt == '0)) begin
        mbusy <= 1'b0;
        mdone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma <= m_opa;
      mb <= m_opb;
      mp <= '0;
      mcnt <= CW'(WIDTH - 1);
      mphase <= 1'b0;
    end else if (mbusy) begin
      mp <= m_sum;
      mphase <= ~mphase;
      if (mphase) begin
        mcnt <= mcnt - CW'(1);
      end
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      DSEL_GMOD: begin d_num = graw; d_den = n;   end
      DSEL_GCD:  begin d_num = dvd;  d_den = dvs; end
      DSEL_QUOT: begin d_num = n;    d_den = dvs; end
      default:   begin d_num = graw; d_den = n;   end
    endcase
  end

  assign d_t = {drm, dq[WIDTH-1]};
  assign d_ge = (d_t >= {1'b0, dd});
  assign d_diff = d_t - {1'b0, dd};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (cmd.div_start) begin
        dbusy <= 1'b1;
      end else if (dbusy && (dcnt == '0)) begin
        dbusy <= 1'b0;
        ddone <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq <= d_num;
      drm <= '0;
      dd <= d_den;
      dcnt <= CW'(WIDTH - 1);
    end else if (dbusy) begin
      drm <= d_ge ? d_diff[WIDTH-1:0] : d_t[WIDTH-1:0];
      dq <= {dq[WIDTH-2:0], d_ge};
      dcnt <= dcnt - CW'(1);
    end
  end

  // operand registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= WIDTH'(in_data.modulus);
      graw <= WIDTH'(in_data.base);
    end
    if (cmd.init_g) begin
      g <= drm;
      acc <= WIDTH'(1);
      r <= ORDER_W'(1);
    end
    if (cmd.acc_take) begin
      acc <= mp;
      r <= r + ORDER_W'(1);
    end
    if (cmd.pow_init) begin
      res <= WIDTH'(1);
      expo <= r >> 1;
      k <= '1;
    end
    if (cmd.res_take) begin
      res <= mp;
    end
    if (cmd.k_dec) begin
      k <= k - EXP_IDX_W'(1);
    end
    if (cmd.gcd_init) begin
      dvd <= res + WIDTH'(1);
      dvs <= n;
    end
    if (cmd.gcd_step) begin
      dvd <= dvs;
      dvs <= drm;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_fail) begin
        out_data <= '{factor_a: '0, factor_b: '0, order: '0, status: 1'b1};
      end else begin
        out_data <= '{factor_a: FIELD_W'(dvs), factor_b: FIELD_W'(dq),
                      order: r, status: 1'b0};
      end
    end
  end

  assign st.n_ge2 = (n > WIDTH'(1));
  assign st.limit_zero = (limit == '0);
  assign st.mul_done = mdone;
  assign st.div_done = ddone;
  assign st.prod_one = (mp == WIDTH'(1));
  assign st.r_last = (r == limit);
  assign st.rem_zero = (drm == '0);
  assign st.exp_bit = expo[k];
  assign st.k_zero = (k == '0);
  assign st.out_free = !out_valid || !out_stall;

endmodule

/* design/order_finding_factor_split.sv */
// ---------------------------------------------------------------------------
// order_finding_factor_split: multiplicative order search and factor split
// Finds the order r of base mod modulus, then gcd(base^(r/2)+1, modulus)
// and modulus divided by that gcd.
// ---------------------------------------------------------------------------
//  channel  | signals                          | direction
//  in       | in_valid, in_stall, in_data      | item in
//  out      | out_valid, out_stall, out_data   | result out
//  cfg      | cfg_write, cfg_data              | attempt limit write
//
// One item at a time; the modular multiply and the division are bit serial.
// An item costs a division for the base reduction, a multiply per exponent
// tried, a square plus a multiply where the bit is set for each of the 16
// exponent bits of the power, a division per gcd step and a final division.
// Reset clears control and sets the limit to 1000. The result waits in the
// output register under stall while the next item may already be taken in.
// ---------------------------------------------------------------------------
module order_finding_factor_split import ofs_pkg::*; #(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ofs_in_t            in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ofs_out_t           out_data,
  input  logic               cfg_write,
  input  logic [ORDER_W-1:0] cfg_data
);

  localparam logic [ORDER_W-1:0] LIMIT_RESET = ORDER_W'(1000);

  logic [ORDER_W-1:0] attempt_limit;
  ofs_cmd_t           cmd;
  ofs_status_t        st;

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= LIMIT_RESET;
    end else if (cfg_write) begin
      attempt_limit <= cfg_data;
    end
  end

  ofs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ofs_dp #(.WIDTH(WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .limit     (attempt_limit),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |->
      (out_data.order == '0 && out_data.factor_a == '0 && out_data.factor_b == '0))
    else $error("failed result carries nonzero fields");

  a_found_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.status) |->
      (out_data.order != '0 && out_data.factor_a != '0))
    else $error("found result with zero order or factor");
`endif

endmodule
